// ----- sv/iec_pkg.sv -----
// Shared types, character codes and decode function for the expression evaluator.
package iec_pkg;

  localparam int VALUE_WIDTH = 32;

  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;
  localparam logic [7:0] CHAR_PLUS   = 8'h2B;
  localparam logic [7:0] CHAR_MINUS  = 8'h2D;
  localparam logic [7:0] CHAR_TIMES  = 8'h2A;
  localparam logic [7:0] CHAR_DIVIDE = 8'h2F;
  localparam logic [7:0] CHAR_EQUALS = 8'h3D;

  typedef enum logic [2:0] {
    CH_DIGIT,
    CH_PLUS,
    CH_MINUS,
    CH_TIMES,
    CH_DIVIDE,
    CH_EQUALS,
    CH_OTHER
  } char_class_t;

  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_TIMES,
    MUL_DIVIDE
  } mul_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLOSE,
    S_CALC,
    S_APPLY,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic    digit_load;
    logic    num_close_direct;
    logic    term_zero_err;
    logic    mdu_start;
    logic    mdu_op_div;
    logic    term_load_mdu;
    logic    term_close;
    logic    add_op_set;
    logic    add_op_val;
    logic    mul_op_load;
    mul_op_t mul_op_val;
    logic    out_load;
    logic    clear;
  } iec_cmd_t;

  typedef struct packed {
    mul_op_t mul_op;
    logic    num_zero;
    logic    mdu_busy;
  } iec_sts_t;

  function automatic char_class_t char_class(input logic [7:0] code);
    char_class_t cls;
    if (code >= CHAR_ZERO && code <= CHAR_NINE) begin
      cls = CH_DIGIT;
    end else begin
      unique case (code)
        CHAR_PLUS:   cls = CH_PLUS;
        CHAR_MINUS:  cls = CH_MINUS;
        CHAR_TIMES:  cls = CH_TIMES;
        CHAR_DIVIDE: cls = CH_DIVIDE;
        CHAR_EQUALS: cls = CH_EQUALS;
        default:     cls = CH_OTHER;
      endcase
    end
    return cls;
  endfunction

endpackage

// ----- sv/infix_integer_expression_evaluator.sv -----
// Top level of the streaming infix integer expression evaluator.
// One ASCII character is taken per input transfer. A digit or an ignored character is taken in
// the idle state. An operator or '=' passes through the close and apply steps; when a '*' or
// '/' is pending, a calc step between them waits for the shared multiply/divide unit, which
// resolves one bit per cycle. A '/' with a zero divisor skips the unit. '=' adds an emit step
// to load the result register, and waits there while an earlier result has not yet been
// transferred.
// Arithmetic wraps at DATA_WIDTH bits; value is the result sign-extended or truncated to
// 32 bits, and is 0 with div_by_zero set when any division had a zero divisor.
module infix_integer_expression_evaluator import iec_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    char_code,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [VALUE_WIDTH-1:0] value,
  output logic                          div_by_zero
);

  iec_cmd_t cmd;
  iec_sts_t sts;

  iec_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .char_code(char_code),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  iec_dp #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .char_code  (char_code),
    .cmd        (cmd),
    .sts        (sts),
    .value      (value),
    .div_by_zero(div_by_zero)
  );

endmodule

// ----- sv/iec_mdu.sv -----
// Shared multiply/divide unit: shift-add multiply and restoring divide, one bit per cycle.
module iec_mdu import iec_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  op_div,
  input  logic [DATA_WIDTH-1:0] operand_a,
  input  logic [DATA_WIDTH-1:0] operand_b,
  output logic                  busy,
  output logic [DATA_WIDTH-1:0] result
);

  localparam int CntWidth = $clog2(DATA_WIDTH + 1);

  logic [CntWidth-1:0]   cnt;
  logic [DATA_WIDTH-1:0] acc;
  logic [DATA_WIDTH-1:0] opa;
  logic [DATA_WIDTH-1:0] opb;
  logic                  is_div;
  logic                  neg;

  logic [DATA_WIDTH-1:0] mag_a;
  logic [DATA_WIDTH-1:0] mag_b;
  logic [DATA_WIDTH:0]   rem_sh;
  logic [DATA_WIDTH:0]   diff;
  logic                  diff_ok;

  // Magnitudes fit in DATA_WIDTH bits as unsigned, including the most negative value.
  assign mag_a   = operand_a[DATA_WIDTH-1] ? (~operand_a + 1'b1) : operand_a;
  assign mag_b   = operand_b[DATA_WIDTH-1] ? (~operand_b + 1'b1) : operand_b;
  assign rem_sh  = {acc, opa[DATA_WIDTH-1]};
  assign diff    = rem_sh - {1'b0, opb};
  assign diff_ok = ~diff[DATA_WIDTH];

  assign busy   = (cnt != '0);
  assign result = is_div ? (neg ? (~opa + 1'b1) : opa) : acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CntWidth'(DATA_WIDTH);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      is_div <= op_div;
      acc    <= '0;
      if (op_div) begin
        opa <= mag_a;
        opb <= mag_b;
        neg <= operand_a[DATA_WIDTH-1] ^ operand_b[DATA_WIDTH-1];
      end else begin
        opa <= operand_a;
        opb <= operand_b;
        neg <= 1'b0;
      end
    end else if (busy) begin
      if (is_div) begin
        // The quotient bits shift into opa as the dividend bits shift out.
        acc <= diff_ok ? diff[DATA_WIDTH-1:0] : rem_sh[DATA_WIDTH-1:0];
        opa <= {opa[DATA_WIDTH-2:0], diff_ok};
      end else begin
        if (opb[0]) begin
          acc <= acc + opa;
        end
        opa <= {opa[DATA_WIDTH-2:0], 1'b0};
        opb <= {1'b0, opb[DATA_WIDTH-1:1]};
      end
    end
  end

endmodule

// ----- sv/iec_dp.sv -----
// Datapath: number, term and sum registers, the multiply/divide unit and the result register.
module iec_dp import iec_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [7:0]                    char_code,
  input  iec_cmd_t                      cmd,
  output iec_sts_t                      sts,
  output logic signed [VALUE_WIDTH-1:0] value,
  output logic                          div_by_zero
);

  logic [DATA_WIDTH-1:0]  running_sum;
  logic [DATA_WIDTH-1:0]  running_term;
  logic [DATA_WIDTH-1:0]  current_number;
  logic                   additive_op;
  mul_op_t                multiplicative_op;
  logic                   error_seen;

  logic [3:0]             digit_val;
  logic [DATA_WIDTH-1:0]  number_next;
  logic [DATA_WIDTH-1:0]  sum_next;
  logic [DATA_WIDTH-1:0]  mdu_result;
  logic                   mdu_busy;
  logic [VALUE_WIDTH-1:0] sum_ext;

  assign digit_val   = 4'(char_code - CHAR_ZERO);
  assign number_next = {current_number[DATA_WIDTH-4:0], 3'b000}
                     + {current_number[DATA_WIDTH-2:0], 1'b0}
                     + DATA_WIDTH'(digit_val);
  assign sum_next    = additive_op ? (running_sum - running_term)
                                   : (running_sum + running_term);

  generate
    if (DATA_WIDTH >= VALUE_WIDTH) begin : g_trunc
      assign sum_ext = running_sum[VALUE_WIDTH-1:0];
    end else begin : g_sext
      assign sum_ext = {{(VALUE_WIDTH - DATA_WIDTH){running_sum[DATA_WIDTH-1]}}, running_sum};
    end
  endgenerate

  iec_mdu #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_mdu (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.mdu_start),
    .op_div   (cmd.mdu_op_div),
    .operand_a(running_term),
    .operand_b(current_number),
    .busy     (mdu_busy),
    .result   (mdu_result)
  );

  assign sts.mul_op   = multiplicative_op;
  assign sts.num_zero = (current_number == '0);
  assign sts.mdu_busy = mdu_busy;

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      running_sum       <= '0;
      running_term      <= '0;
      current_number    <= '0;
      additive_op       <= 1'b0;
      multiplicative_op <= MUL_NONE;
      error_seen        <= 1'b0;
    end else begin
      if (cmd.digit_load) begin
        current_number <= number_next;
      end
      if (cmd.num_close_direct) begin
        running_term   <= current_number;
        current_number <= '0;
      end
      if (cmd.term_zero_err) begin
        running_term   <= '0;
        current_number <= '0;
        error_seen     <= 1'b1;
      end
      if (cmd.term_load_mdu) begin
        running_term   <= mdu_result;
        current_number <= '0;
      end
      if (cmd.term_close) begin
        running_sum       <= sum_next;
        running_term      <= '0;
        multiplicative_op <= MUL_NONE;
      end
      if (cmd.add_op_set) begin
        additive_op <= cmd.add_op_val;
      end
      if (cmd.mul_op_load) begin
        multiplicative_op <= cmd.mul_op_val;
      end
    end
  end

  // The result register is loaded before the clear takes effect.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      value       <= error_seen ? '0 : sum_ext;
      div_by_zero <= error_seen;
    end
  end

endmodule

// ----- sv/iec_ctrl.sv -----
// Controller state machine: decodes characters and sequences the datapath.
module iec_ctrl import iec_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] char_code,
  output logic       out_valid,
  input  logic       out_stall,
  output iec_cmd_t   cmd,
  input  iec_sts_t   sts
);

  state_t      state;
  state_t      state_next;
  char_class_t pend;
  char_class_t in_class;
  logic        in_xfer;
  logic        out_free;

  assign in_class = char_class(char_code);
  assign in_stall = (state != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= cmd.out_load || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      pend <= in_class;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_xfer && in_class != CH_DIGIT && in_class != CH_OTHER) begin
          state_next = S_CLOSE;
        end
      end
      S_CLOSE: begin
        if (sts.mul_op == MUL_NONE ||
            (sts.mul_op == MUL_DIVIDE && sts.num_zero)) begin
          state_next = S_APPLY;
        end else begin
          state_next = S_CALC;
        end
      end
      S_CALC: begin
        if (!sts.mdu_busy) begin
          state_next = S_APPLY;
        end
      end
      S_APPLY: begin
        state_next = (pend == CH_EQUALS) ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.mul_op_val = MUL_NONE;
    unique case (state)
      S_IDLE: begin
        cmd.digit_load = in_xfer && (in_class == CH_DIGIT);
      end
      S_CLOSE: begin
        if (sts.mul_op == MUL_NONE) begin
          cmd.num_close_direct = 1'b1;
        end else if (sts.mul_op == MUL_DIVIDE && sts.num_zero) begin
          cmd.term_zero_err = 1'b1;
        end else begin
          cmd.mdu_start  = 1'b1;
          cmd.mdu_op_div = (sts.mul_op == MUL_DIVIDE);
        end
      end
      S_CALC: begin
        cmd.term_load_mdu = !sts.mdu_busy;
      end
      S_APPLY: begin
        case (pend) inside
          CH_PLUS, CH_MINUS: begin
            cmd.term_close = 1'b1;
            cmd.add_op_set = 1'b1;
            cmd.add_op_val = (pend == CH_MINUS);
          end
          CH_TIMES: begin
            cmd.mul_op_load = 1'b1;
            cmd.mul_op_val  = MUL_TIMES;
          end
          CH_DIVIDE: begin
            cmd.mul_op_load = 1'b1;
            cmd.mul_op_val  = MUL_DIVIDE;
          end
          CH_EQUALS: begin
            cmd.term_close = 1'b1;
          end
          default: begin
          end
        endcase
      end
      S_EMIT: begin
        cmd.out_load = out_free;
        cmd.clear    = out_free;
      end
      default: begin
      end
    endcase
  end

  // A started operation must keep the unit busy on the following cycle.
  assert property (@(posedge clk) disable iff (rst) cmd.mdu_start |=> sts.mdu_busy)
    else $error("multiply/divide unit not busy after start");

  // A new result never overwrites one that is still waiting for its transfer.
  assert property (@(posedge clk) disable iff (rst)
                   cmd.out_load |-> (!out_valid || !out_stall))
    else $error("result register overwritten while stalled");

  // An accepted '=' always leads into the close step.
  assert property (@(posedge clk) disable iff (rst)
                   (in_xfer && in_class == CH_EQUALS) |=> (state == S_CLOSE))
    else $error("terminator not followed by close step");

  // The datapath is cleared only together with a result load.
  assert property (@(posedge clk) disable iff (rst) cmd.clear |-> cmd.out_load)
    else $error("state cleared without a result");

endmodule
